// ===== src/fwsc_pkg.sv =====
// ---------------------------------------------------------------------------
// fwsc_pkg
// Shared types, constants and the sine table generator of the flanger unit.
// ---------------------------------------------------------------------------
`default_nettype none
package fwsc_pkg;

   localparam int HISTORY_DEPTH_DEF      = 4096;
   localparam int SINE_TABLE_ENTRIES_DEF = 256;

   // shared serial multiplier: signed multiplicand, unsigned multiplier
   localparam int MCW   = 27;
   localparam int MPW   = 32;
   localparam int PW    = MCW + MPW;
   localparam int MUL_CW = 6;

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_IW-1:0] CSR_PHASE_STEP  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_BASE_DELAY  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_SWEEP_DEPTH = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_THRESHOLD   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_COMP_RATIO  = 3'd4;

   localparam logic [14:0] THRESHOLD_RST  = 15'd32767;
   localparam logic [15:0] COMP_RATIO_RST = 16'd32768;

   typedef struct packed {
      logic              start;
      logic [MUL_CW-1:0] nbits;
   } mul_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_IDX_GO, ST_IDX_WAIT, ST_SINE, ST_DLY_GO, ST_DLY_WAIT, ST_ADDR,
      ST_RD_OLD, ST_RD_NEW, ST_TAP_GO, ST_TAP_WAIT, ST_CMP_GO, ST_CMP_WAIT, ST_OUT
   } state_type;

   // Q1.15 sine of an angle in turns * 2^32, odd polynomial on a folded quadrant
   function automatic logic signed [15:0] sine_of_angle(input longint unsigned ang);
      longint unsigned q1;
      longint unsigned x;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned p;
      longint unsigned s;
      logic [1:0]      q;
      q1 = 64'd1 << 30;
      q  = ang[31:30];
      x  = ang & (q1 - 64'd1);
      t  = q[0] ? (q1 - x) : x;
      t2 = (t * t) >> 30;
      p  = 64'd85569306 - ((t2 * 64'd5026995) >> 30);
      p  = 64'd693598668 - ((t2 * p) >> 30);
      p  = 64'd1686629713 - ((t2 * p) >> 30);
      s  = ((t * p) >> 30) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return q[1] ? -16'(s) : 16'(s);
   endfunction

endpackage
`default_nettype wire

// ===== src/fwsc_smul.sv =====
// ---------------------------------------------------------------------------
// fwsc_smul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module fwsc_smul (
   input  wire                             clock,
   input  wire                             reset,
   input  fwsc_pkg::mul_ctl_type           ctl,
   input  wire  signed [fwsc_pkg::MCW-1:0] mcand,
   input  wire         [fwsc_pkg::MPW-1:0] mplier,
   output logic                            done,
   output logic signed [fwsc_pkg::PW-1:0]  prod
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [fwsc_pkg::MUL_CW-1:0]       cnt_ff;
   logic signed [fwsc_pkg::PW-1:0]    mcand_ff;
   logic [fwsc_pkg::MPW-1:0]          mplier_ff;
   logic signed [fwsc_pkg::PW-1:0]    acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= ctl.nbits;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == fwsc_pkg::MUL_CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mcand_ff  <= fwsc_pkg::PW'(mcand);
         mplier_ff <= mplier;
         acc_ff    <= '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// ===== src/flanger_with_soft_compression_unit.sv =====
// Each accepted item computes the phase index, the sweep product, the interpolated tap and
// compression in turn, each on the shared serial multiplier.
// The tap is skipped when out of range, compression when inside the knee.
// Only one item is in flight at a time, since the serial multiplier is shared by all steps.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) clears pointers, fill count, LFO phase and the response
// valid flag, and resets the configuration registers; history contents are not cleared.
// ---------------------------------------------------------------------------
// flanger_with_soft_compression_unit
// Sine-swept interpolated delay flanger with soft knee compression.
// ---------------------------------------------------------------------------
`default_nettype none
module flanger_with_soft_compression_unit #(
   parameter int HISTORY_DEPTH      = fwsc_pkg::HISTORY_DEPTH_DEF,
   parameter int SINE_TABLE_ENTRIES = fwsc_pkg::SINE_TABLE_ENTRIES_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [15:0]                  req_tdata,   // [15:0] in_sample
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [15:0]                  rsp_tdata,   // [15:0] out_sample
   input  wire                          csr_we,
   input  wire  [fwsc_pkg::CSR_IW-1:0]  csr_index,
   input  wire  [fwsc_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int IW = $clog2(SINE_TABLE_ENTRIES);
   localparam int EW = ((CW > 14) ? CW : 14) + 1;
   localparam int YW = 26;

   // configuration
   logic [31:0] phase_step_ff;
   logic [19:0] base_delay_ff;
   logic [19:0] sweep_depth_ff;
   logic [14:0] threshold_ff;
   logic [15:0] comp_ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         base_delay_ff  <= '0;
         sweep_depth_ff <= '0;
         threshold_ff   <= fwsc_pkg::THRESHOLD_RST;
         comp_ratio_ff  <= fwsc_pkg::COMP_RATIO_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            fwsc_pkg::CSR_PHASE_STEP:  phase_step_ff  <= csr_wdata;
            fwsc_pkg::CSR_BASE_DELAY:  base_delay_ff  <= csr_wdata[19:0];
            fwsc_pkg::CSR_SWEEP_DEPTH: sweep_depth_ff <= csr_wdata[19:0];
            fwsc_pkg::CSR_THRESHOLD:   threshold_ff   <= csr_wdata[14:0];
            fwsc_pkg::CSR_COMP_RATIO:  comp_ratio_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // sine table, built at elaboration
   logic signed [15:0] sine_rom [SINE_TABLE_ENTRIES];
   for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++) begin : g_rom
      localparam longint unsigned ANG = (64'(g) << 32) / SINE_TABLE_ENTRIES;
      assign sine_rom[g] = fwsc_pkg::sine_of_angle(ANG);
   end

   // control state
   fwsc_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       wp_ff;
   logic [CW-1:0]       filled_ff;
   logic [31:0]         phase_ff;
   logic                rsp_valid_ff;

   // datapath
   logic signed [15:0]     dry_ff;
   logic signed [15:0]     sine_ff;
   logic signed [YW-1:0]   y_ff;
   logic [8:0]             w_ff;
   logic                   tap_ok_ff;
   logic                   comp_hi_ff;
   logic [AW-1:0]          addr_ff;
   logic [AW-1:0]          newer_pos_ff;
   logic signed [15:0]     rd_q_ff;
   logic signed [15:0]     older_ff;
   logic [15:0]            rsp_data_ff;
   logic signed [15:0]     hist_mem [HISTORY_DEPTH];

   // serial multiplier
   fwsc_pkg::mul_ctl_type              mul_ctl;
   logic signed [fwsc_pkg::MCW-1:0]    mul_mcand;
   logic [fwsc_pkg::MPW-1:0]           mul_mplier;
   logic                               mul_done;
   logic signed [fwsc_pkg::PW-1:0]     mul_prod;

   fwsc_smul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .mcand  (mul_mcand),
      .mplier (mul_mplier),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   wire req_acc = req_tvalid && req_tready;

   // delay, tap address, knee test and output saturation
   logic signed [21:0] dly;
   logic signed [14:0] ob;
   logic [EW-1:0]      obu;
   logic [AW-1:0]      back;
   logic [AW:0]        pos_o, pos_n;
   logic               tap_ok;
   logic [8:0]         w_in;
   logic signed [YW-1:0] thr_y;
   logic                 above, below;
   logic signed [YW-1:0] excess;
   logic signed [17:0]   r;
   logic [15:0]          sat;

   always_comb begin
      dly    = $signed({2'b00, base_delay_ff}) + $signed(mul_prod[36:15]);
      ob     = $signed({dly[21], dly[21:8]}) + $signed({14'd0, (dly[7:0] != 8'd0)});
      obu    = EW'(ob[13:0]);
      tap_ok = !ob[14] && (ob != 15'sd0) && (obu < EW'(filled_ff));
      back   = obu[AW-1:0];
      pos_o  = {1'b0, wp_ff} - {1'b0, back};
      if (pos_o[AW]) pos_o = pos_o + (AW+1)'(HISTORY_DEPTH);
      pos_n  = {1'b0, wp_ff} - {1'b0, back} + (AW+1)'(1);
      if (pos_n[AW]) pos_n = pos_n + (AW+1)'(HISTORY_DEPTH);
      w_in   = (dly[7:0] == 8'd0) ? 9'd0 : 9'd256 - {1'b0, dly[7:0]};
      thr_y  = $signed({3'b000, threshold_ff, 8'd0});
      above  = y_ff > thr_y;
      below  = y_ff < -thr_y;
      excess = above ? (y_ff - thr_y) : (y_ff + thr_y);
      r      = y_ff[YW-1:8];
      if (r > 18'sd32767)       sat = 16'h7FFF;
      else if (r < -18'sd32768) sat = 16'h8000;
      else                      sat = r[15:0];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) state_ff <= fwsc_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in      = state_ff;
      mul_ctl.start = 1'b0;
      mul_ctl.nbits = '0;
      mul_mcand     = '0;
      mul_mplier    = '0;
      req_tready    = 1'b0;
      unique case (state_ff)
         fwsc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = fwsc_pkg::ST_IDX_GO;
         end
         fwsc_pkg::ST_IDX_GO: begin
            mul_ctl.start = 1'b1;
            mul_ctl.nbits = fwsc_pkg::MUL_CW'(32);
            mul_mcand     = fwsc_pkg::MCW'(SINE_TABLE_ENTRIES);
            mul_mplier    = phase_ff;
            state_in      = fwsc_pkg::ST_IDX_WAIT;
         end
         fwsc_pkg::ST_IDX_WAIT: if (mul_done) state_in = fwsc_pkg::ST_SINE;
         fwsc_pkg::ST_SINE:     state_in = fwsc_pkg::ST_DLY_GO;
         fwsc_pkg::ST_DLY_GO: begin
            mul_ctl.start = 1'b1;
            mul_ctl.nbits = fwsc_pkg::MUL_CW'(20);
            mul_mcand     = fwsc_pkg::MCW'(sine_ff);
            mul_mplier    = fwsc_pkg::MPW'(sweep_depth_ff);
            state_in      = fwsc_pkg::ST_DLY_WAIT;
         end
         fwsc_pkg::ST_DLY_WAIT: if (mul_done) state_in = fwsc_pkg::ST_ADDR;
         fwsc_pkg::ST_ADDR:
            state_in = tap_ok ? fwsc_pkg::ST_RD_OLD : fwsc_pkg::ST_CMP_GO;
         fwsc_pkg::ST_RD_OLD: state_in = fwsc_pkg::ST_RD_NEW;
         fwsc_pkg::ST_RD_NEW: state_in = fwsc_pkg::ST_TAP_GO;
         fwsc_pkg::ST_TAP_GO: begin
            mul_ctl.start = 1'b1;
            mul_ctl.nbits = fwsc_pkg::MUL_CW'(9);
            mul_mcand     = fwsc_pkg::MCW'(17'(rd_q_ff) - 17'(older_ff));
            mul_mplier    = fwsc_pkg::MPW'(w_ff);
            state_in      = fwsc_pkg::ST_TAP_WAIT;
         end
         fwsc_pkg::ST_TAP_WAIT: if (mul_done) state_in = fwsc_pkg::ST_CMP_GO;
         fwsc_pkg::ST_CMP_GO: begin
            if (above || below) begin
               mul_ctl.start = 1'b1;
               mul_ctl.nbits = fwsc_pkg::MUL_CW'(16);
               mul_mcand     = fwsc_pkg::MCW'(excess);
               mul_mplier    = fwsc_pkg::MPW'(comp_ratio_ff);
               state_in      = fwsc_pkg::ST_CMP_WAIT;
            end else begin
               state_in = fwsc_pkg::ST_OUT;
            end
         end
         fwsc_pkg::ST_CMP_WAIT: if (mul_done) state_in = fwsc_pkg::ST_OUT;
         fwsc_pkg::ST_OUT: if (!rsp_valid_ff || rsp_tready) state_in = fwsc_pkg::ST_IDLE;
         default: state_in = fwsc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         filled_ff    <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_acc && filled_ff != CW'(HISTORY_DEPTH)) filled_ff <= filled_ff + 1'b1;
         if (state_ff == fwsc_pkg::ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_ff + phase_step_ff;
            wp_ff        <= (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // history ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_acc) hist_mem[wp_ff] <= req_tdata;
      rd_q_ff <= hist_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         fwsc_pkg::ST_IDLE: if (req_acc) dry_ff <= req_tdata;
         fwsc_pkg::ST_SINE: sine_ff <= sine_rom[mul_prod[32 +: IW]];
         fwsc_pkg::ST_ADDR: begin
            y_ff         <= YW'(dry_ff) <<< 8;
            w_ff         <= w_in;
            tap_ok_ff    <= tap_ok;
            addr_ff      <= pos_o[AW-1:0];
            newer_pos_ff <= pos_n[AW-1:0];
         end
         fwsc_pkg::ST_RD_OLD: addr_ff <= newer_pos_ff;
         fwsc_pkg::ST_RD_NEW: older_ff <= rd_q_ff;
         fwsc_pkg::ST_TAP_GO: y_ff <= y_ff + (YW'(older_ff) <<< 8);
         fwsc_pkg::ST_TAP_WAIT: if (mul_done) y_ff <= y_ff + mul_prod[YW-1:0];
         fwsc_pkg::ST_CMP_GO: comp_hi_ff <= above;
         fwsc_pkg::ST_CMP_WAIT:
            if (mul_done) y_ff <= (comp_hi_ff ? thr_y : -thr_y) + mul_prod[16 +: YW];
         fwsc_pkg::ST_OUT: if (!rsp_valid_ff || rsp_tready) rsp_data_ff <= sat;
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CW'(HISTORY_DEPTH))
      else $error("fill count beyond history depth");
   a_tap_in_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == fwsc_pkg::ST_RD_OLD |-> tap_ok_ff && filled_ff >= CW'(2))
      else $error("history read without enough samples");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == fwsc_pkg::ST_OUT && rsp_valid_ff && !rsp_tready
      |=> state_ff == fwsc_pkg::ST_OUT && $stable(phase_ff))
      else $error("result overwritten while pending");
`endif

endmodule
`default_nettype wire
